@@ hdl/rle_pkg.sv @@
// Shared types, codes and constants of the RGB LED effect engine.
package rle_pkg;

	// Effect mode codes
	localparam logic [2:0] MODE_NONE       = 3'd0;
	localparam logic [2:0] MODE_FLASH      = 3'd1;
	localparam logic [2:0] MODE_BREATHE    = 3'd2;
	localparam logic [2:0] MODE_CYCLE      = 3'd3;
	localparam logic [2:0] MODE_TRANSITION = 3'd4;

	// Configuration register indexes
	localparam logic [2:0] REG_EFFECT_MODE      = 3'd0;
	localparam logic [2:0] REG_PRIMARY_COLOR    = 3'd1;
	localparam logic [2:0] REG_ALTERNATE_COLOR  = 3'd2;
	localparam logic [2:0] REG_PEAK_BRIGHTNESS  = 3'd3;
	localparam logic [2:0] REG_FLOOR_BRIGHTNESS = 3'd4;
	localparam logic [2:0] REG_STEP_INTERVAL    = 3'd5;
	localparam logic [2:0] REG_REPEAT_COUNT     = 3'd6;

	localparam int CfgIndexW = 3;
	localparam int CfgDataW  = 24;

	localparam logic [10:0] MIN_STEP_MS = 11'd20;
	localparam logic [10:0] RESET_STEP  = 11'd20;
	localparam logic [7:0]  PHASE_STEP  = 8'd8;
	localparam logic [7:0]  RESET_PEAK  = 8'd255;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic capture;   // latch the accepted request
		logic update;    // advance effect state for the request
		logic render_a;  // first render step: interpolation and level products
		logic render_b;  // second render step: channel scaling into shown color
		logic load_out;  // move the result into the output registers
	} rle_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic need_render;
	} rle_stat_t;

endpackage

@@ hdl/rle_ctrl.sv @@
// Controller state machine of the RGB LED effect engine.
module rle_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  rle_pkg::rle_stat_t stat,
	output rle_pkg::rle_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_RENDER_A,
		ST_RENDER_B,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || out_ready;

	// Decode commands from the current state
	always_comb begin
		cmd          = '0;
		cmd.capture  = (state_q == ST_IDLE) && in_valid;
		cmd.update   = (state_q == ST_UPDATE);
		cmd.render_a = (state_q == ST_RENDER_A);
		cmd.render_b = (state_q == ST_RENDER_B);
		cmd.load_out = (state_q == ST_DONE) && slot_free;
	end

	// Sequence one request and hold the output slot flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// raise the flag on a load, drop it once the result is taken
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					state_q <= stat.need_render ? ST_RENDER_A : ST_DONE;
				end
				ST_RENDER_A: begin
					state_q <= ST_RENDER_B;
				end
				ST_RENDER_B: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ hdl/rle_dp.sv @@
// Datapath of the RGB LED effect engine: registers, effect state and renderer.
module rle_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rle_pkg::CfgIndexW-1:0]  cfg_index,
	input  logic [rle_pkg::CfgDataW-1:0]   cfg_data,
	input  logic                           restart,
	input  logic                           tick,
	input  rle_pkg::rle_cmd_t              cmd,
	output rle_pkg::rle_stat_t             stat,
	output logic [7:0]                     red_out,
	output logic [7:0]                     green_out,
	output logic [7:0]                     blue_out,
	output logic                           running,
	output logic                           rejected
);

	// Configuration registers
	logic [2:0]  effect_mode_q;
	logic [23:0] primary_color_q;
	logic [23:0] alternate_color_q;
	logic [7:0]  peak_q;
	logic [7:0]  floor_q;
	logic [10:0] step_interval_q;
	logic [7:0]  repeat_count_q;

	// Effect state
	logic [7:0]  phase_q;
	logic [10:0] elapsed_q;
	logic [7:0]  repeats_q;
	logic        active_q;
	logic [23:0] base_q;
	logic [23:0] shown_q;

	// Per-request registers
	logic restart_q;
	logic tick_q;
	logic rej_q;
	logic plain_q;

	// Render pipeline registers
	logic signed [17:0] prod_s1 [3];
	logic [16:0]        breathe_s1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			effect_mode_q     <= rle_pkg::MODE_NONE;
			primary_color_q   <= '0;
			alternate_color_q <= '0;
			peak_q            <= rle_pkg::RESET_PEAK;
			floor_q           <= '0;
			step_interval_q   <= rle_pkg::RESET_STEP;
			repeat_count_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rle_pkg::REG_EFFECT_MODE:      effect_mode_q     <= cfg_data[2:0];
				rle_pkg::REG_PRIMARY_COLOR:    primary_color_q   <= cfg_data[23:0];
				rle_pkg::REG_ALTERNATE_COLOR:  alternate_color_q <= cfg_data[23:0];
				rle_pkg::REG_PEAK_BRIGHTNESS:  peak_q            <= cfg_data[7:0];
				rle_pkg::REG_FLOOR_BRIGHTNESS: floor_q           <= cfg_data[7:0];
				rle_pkg::REG_STEP_INTERVAL:    step_interval_q   <= cfg_data[10:0];
				rle_pkg::REG_REPEAT_COUNT:     repeat_count_q    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Next effect state for the latched request
	logic        cfg_ok;
	logic [10:0] elapsed_inc;
	logic [7:0]  phase_next;
	logic [7:0]  repeats_dec;
	logic        step_due;
	logic        wrapped;

	assign cfg_ok = (effect_mode_q != rle_pkg::MODE_NONE)
		&& (effect_mode_q <= rle_pkg::MODE_TRANSITION)
		&& (step_interval_q >= rle_pkg::MIN_STEP_MS)
		&& (floor_q <= peak_q);
	assign elapsed_inc = elapsed_q + 11'd1;
	assign step_due    = (elapsed_inc >= step_interval_q);
	assign phase_next  = phase_q + rle_pkg::PHASE_STEP;
	assign wrapped     = (phase_next < phase_q);
	assign repeats_dec = repeats_q - 8'd1;

	// Render after an accepted restart or a due step (phase step or effect end), decided during the update
	assign stat.need_render = (restart_q && cfg_ok) || (tick_q && active_q && step_due);

	// Latch the request and advance effect state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= '0;
			elapsed_q     <= '0;
			repeats_q     <= '0;
			active_q      <= 1'b0;
			base_q        <= '0;
			rej_q         <= 1'b0;
			plain_q       <= 1'b0;
			restart_q     <= 1'b0;
			tick_q        <= 1'b0;
		end else begin
			if (cmd.capture) begin
				restart_q <= restart;
				tick_q    <= tick;
			end
			if (cmd.update) begin
				rej_q         <= restart_q && !cfg_ok;
				plain_q       <= 1'b0;
				if (restart_q && cfg_ok) begin
					base_q        <= primary_color_q;
					phase_q       <= '0;
					elapsed_q     <= '0;
					repeats_q     <= repeat_count_q;
					active_q      <= 1'b1;
				end else if (tick_q && active_q) begin
					if (step_due) begin
						elapsed_q     <= '0;
						if (wrapped && (repeats_q != 8'd0)) begin
							repeats_q <= repeats_dec;
						end
						if (wrapped && (repeats_q == 8'd1)) begin
							// end the effect: keep phase, show the base at peak
							active_q <= 1'b0;
							plain_q  <= 1'b1;
							if (effect_mode_q == rle_pkg::MODE_TRANSITION) begin
								base_q <= alternate_color_q;
							end
						end else begin
							phase_q <= phase_next;
						end
					end else begin
						elapsed_q <= elapsed_inc;
					end
				end
			end
		end
	end

	// First render step: triangle wave, interpolation and breathe products
	logic [7:0]         tri_wave;
	logic [7:0]         lerp_pos;
	logic [7:0]         span;
	logic signed [8:0]  diff [3];

	assign tri_wave = phase_q[7] ? {~phase_q[6:0], 1'b0} : {phase_q[6:0], 1'b0};
	assign lerp_pos = (effect_mode_q == rle_pkg::MODE_CYCLE) ? tri_wave : phase_q;
	assign span     = peak_q - floor_q;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			diff[i] = $signed({1'b0, alternate_color_q[8*i +: 8]})
				- $signed({1'b0, base_q[8*i +: 8]});
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.render_a) begin
			for (int i = 0; i < 3; i++) begin
				prod_s1[i] <= diff[i] * $signed({1'b0, lerp_pos});
			end
			breathe_s1 <= span * ({1'b0, tri_wave} + 9'd1);
		end
	end

	// Second render step: pick channels and level, then scale
	logic [7:0]         level;
	logic [8:0]         level_inc;
	logic [7:0]         chan_sel [3];
	logic signed [17:0] quot [3];
	logic [16:0]        scaled [3];
	logic               use_lerp;

	assign use_lerp = !plain_q && ((effect_mode_q == rle_pkg::MODE_CYCLE)
		|| (effect_mode_q == rle_pkg::MODE_TRANSITION));
	assign level = (!plain_q && (effect_mode_q == rle_pkg::MODE_BREATHE))
		? floor_q + breathe_s1[15:8] : peak_q;
	assign level_inc = {1'b0, level} + 9'd1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			// divide by 256, truncating toward zero
			quot[i] = prod_s1[i][17] ? ((prod_s1[i] + 18'sd255) >>> 8) : (prod_s1[i] >>> 8);
			if (use_lerp) begin
				chan_sel[i] = base_q[8*i +: 8] + quot[i][7:0];
			end else if (!plain_q && (effect_mode_q == rle_pkg::MODE_FLASH)
				&& (phase_q >= 8'd128)) begin
				chan_sel[i] = alternate_color_q[8*i +: 8];
			end else begin
				chan_sel[i] = base_q[8*i +: 8];
			end
			scaled[i] = chan_sel[i] * level_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shown_q <= '0;
		end else if (cmd.render_b) begin
			for (int i = 0; i < 3; i++) begin
				shown_q[8*i +: 8] <= scaled[i][15:8];
			end
		end
	end

	// Output registers
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			red_out   <= shown_q[23:16];
			green_out <= shown_q[15:8];
			blue_out  <= shown_q[7:0];
			running   <= active_q;
			rejected  <= rej_q;
		end
	end

endmodule

@@ hdl/rgb_led_effect_engine_core.sv @@
// Top level of the RGB LED effect engine: controller and datapath.
//
// One request (restart and/or a one-millisecond tick) yields one result: the
// displayed color, the running flag and whether a restart was rejected. A
// request that renders (an accepted restart, a phase step or the end of an
// effect) passes from acceptance to a loaded result through accept, state
// update, two render steps through the interpolation and brightness
// multipliers, and output load; any other request skips the render steps.
// in_ready is high while the controller is idle, and the output register lets
// the next request be taken while a result waits. Configuration writes land
// at once; the user makes them only while the block is idle (not enforced).
module rgb_led_effect_engine_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rle_pkg::CfgIndexW-1:0] cfg_index,
	input  logic [rle_pkg::CfgDataW-1:0]  cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          restart,
	input  logic                          tick,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [7:0]                    red_out,
	output logic [7:0]                    green_out,
	output logic [7:0]                    blue_out,
	output logic                          running,
	output logic                          rejected
);

	rle_pkg::rle_cmd_t  cmd;
	rle_pkg::rle_stat_t stat;

	rle_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rle_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.restart   (restart),
		.tick      (tick),
		.cmd       (cmd),
		.stat      (stat),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out),
		.running   (running),
		.rejected  (rejected)
	);

endmodule
